@@ hw/rtl/heat_stencil_3d_convective_step_core_macros.svh @@
// assertion macros for the heat stencil core checker
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef HEAT_STENCIL_3D_CONVECTIVE_STEP_CORE_MACROS_SVH
`define HEAT_STENCIL_3D_CONVECTIVE_STEP_CORE_MACROS_SVH

// property checked on every rising clock edge outside reset
`define HS3D_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition in one cycle implies a condition in the next
`define HS3D_ASSERT_NEXT(lbl, pre, post, msg) \
  `HS3D_ASSERT(lbl, (pre) |=> (post), msg)

`endif

@@ hw/rtl/hs3d_pkg.sv @@
// shared types and constants of the 3d heat stencil core
// no dependencies
package hs3d_pkg;

  localparam int unsigned GRID_X    = 16;
  localparam int unsigned GRID_Y    = 16;
  localparam int unsigned GRID_Z    = 8;
  localparam int unsigned CELLS     = GRID_X * GRID_Y * GRID_Z;
  localparam int unsigned ADDR_W    = $clog2(CELLS);
  localparam int unsigned POS_X_W   = 4;
  localparam int unsigned POS_Y_W   = 4;
  localparam int unsigned POS_Z_W   = 3;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned COEF_W    = 16;
  localparam int unsigned DIFF_W    = 35;
  localparam int unsigned ACC_W     = 40;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned STEP_W    = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_X       = 3'd0,
    REG_COEF_Y       = 3'd1,
    REG_COEF_Z       = 3'd2,
    REG_CONV_GAIN_X  = 3'd3,
    REG_CONV_GAIN_Z  = 3'd4,
    REG_COOL_FACE    = 3'd5,
    REG_COOLANT_TEMP = 3'd6,
    REG_SOURCE_GAIN  = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    FACE_NONE = 2'd0,
    FACE_X    = 2'd1,
    FACE_Z    = 2'd2
  } cool_face_e;

  typedef enum logic {
    ACT_LOAD    = 1'b0,
    ACT_COMPUTE = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    RD_CENTER = 2'd0,
    RD_X      = 2'd1,
    RD_Y      = 2'd2,
    RD_Z      = 2'd3
  } rd_sel_e;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  typedef enum logic [2:0] {
    MUL_SRC  = 3'd0,
    MUL_X    = 3'd1,
    MUL_Y    = 3'd2,
    MUL_Z    = 3'd3,
    MUL_CONV = 3'd4
  } mul_sel_e;

  typedef struct packed {
    logic                      action;
    logic [POS_X_W-1:0]        pos_x;
    logic [POS_Y_W-1:0]        pos_y;
    logic [POS_Z_W-1:0]        pos_z;
    logic signed [DATA_W-1:0]  temp_in;
    logic signed [DATA_W-1:0]  heat_in;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  temp_next;
    logic                      is_update;
  } out_item_t;

  typedef struct packed {
    logic     capture;
    logic     load_wr;
    rd_sel_e  rd_sel;
    logic     ld_center;
    logic     ld_diff;
    axis_e    diff_axis;
    mul_sel_e mul_sel;
    logic     acc_en;
    logic     out_load;
    logic     out_result;
    logic     out_update;
  } cmd_t;

  typedef struct packed {
    logic item_compute;
    logic item_inside;
  } status_t;

endpackage

@@ hw/rtl/hs3d_in_if.sv @@
// input item channel of the heat stencil core
// depends on hs3d_pkg
interface hs3d_in_if import hs3d_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/hs3d_out_if.sv @@
// result item channel of the heat stencil core
// depends on hs3d_pkg
interface hs3d_out_if import hs3d_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/hs3d_ram.sv @@
// generic ram: one write port, two read ports with registered read data
// no dependencies
module hs3d_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

@@ hw/rtl/hs3d_datapath.sv @@
// datapath: config registers, voxel stores, neighbor addressing, shared multiplier,
// accumulator and result register; depends on hs3d_pkg and hs3d_ram
module hs3d_datapath import hs3d_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [DATA_W-1:0]     cfg_data_i,
  input  in_item_t              in_data_i,
  input  cmd_t                  cmd_i,
  output status_t               status_o,
  output out_item_t             out_data_o
);

  logic [COEF_W-1:0]        coef_x_q, coef_y_q, coef_z_q, gain_x_q, gain_z_q;
  logic [1:0]               cool_face_q;
  logic signed [DATA_W-1:0] coolant_q;
  logic [DATA_W-1:0]        src_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_x_q    <= '0;
      coef_y_q    <= '0;
      coef_z_q    <= '0;
      gain_x_q    <= '0;
      gain_z_q    <= '0;
      cool_face_q <= '0;
      coolant_q   <= '0;
      src_gain_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_COEF_X:       coef_x_q    <= cfg_data_i[COEF_W-1:0];
        REG_COEF_Y:       coef_y_q    <= cfg_data_i[COEF_W-1:0];
        REG_COEF_Z:       coef_z_q    <= cfg_data_i[COEF_W-1:0];
        REG_CONV_GAIN_X:  gain_x_q    <= cfg_data_i[COEF_W-1:0];
        REG_CONV_GAIN_Z:  gain_z_q    <= cfg_data_i[COEF_W-1:0];
        REG_COOL_FACE:    cool_face_q <= cfg_data_i[1:0];
        REG_COOLANT_TEMP: coolant_q   <= cfg_data_i;
        REG_SOURCE_GAIN:  src_gain_q  <= cfg_data_i;
        default:          coolant_q   <= coolant_q;
      endcase
    end
  end

  // incoming item position
  logic [ADDR_W-1:0] in_idx;
  assign in_idx = ADDR_W'((32'(in_data_i.pos_z) * GRID_Y + 32'(in_data_i.pos_y)) * GRID_X
                          + 32'(in_data_i.pos_x));
  assign status_o.item_compute = (in_data_i.action == ACT_COMPUTE);
  assign status_o.item_inside  = (32'(in_data_i.pos_x) < GRID_X) &&
                                 (32'(in_data_i.pos_y) < GRID_Y) &&
                                 (32'(in_data_i.pos_z) < GRID_Z);

  logic [POS_X_W-1:0] px_q;
  logic [POS_Y_W-1:0] py_q;
  logic [POS_Z_W-1:0] pz_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      px_q <= in_data_i.pos_x;
      py_q <= in_data_i.pos_y;
      pz_q <= in_data_i.pos_z;
    end
  end

  logic [ADDR_W-1:0] idx;
  assign idx = ADDR_W'((32'(pz_q) * GRID_Y + 32'(py_q)) * GRID_X + 32'(px_q));

  localparam logic [ADDR_W-1:0] StrideX = ADDR_W'(1);
  localparam logic [ADDR_W-1:0] StrideY = ADDR_W'(GRID_X);
  localparam logic [ADDR_W-1:0] StrideZ = ADDR_W'(GRID_X * GRID_Y);

  logic x_lo, x_hi, y_lo, y_hi, z_lo, z_hi;
  assign x_lo = (px_q == '0);
  assign x_hi = (px_q == POS_X_W'(GRID_X - 1));
  assign y_lo = (py_q == '0);
  assign y_hi = (py_q == POS_Y_W'(GRID_Y - 1));
  assign z_lo = (pz_q == '0);
  assign z_hi = (pz_q == POS_Z_W'(GRID_Z - 1));

  // on a boundary both ports point at the single inner neighbor
  logic [ADDR_W-1:0] raddr_a, raddr_b;
  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_CENTER: begin
        raddr_a = idx;
        raddr_b = idx;
      end
      RD_X: begin
        raddr_a = x_lo ? idx + StrideX : idx - StrideX;
        raddr_b = x_hi ? idx - StrideX : idx + StrideX;
      end
      RD_Y: begin
        raddr_a = y_lo ? idx + StrideY : idx - StrideY;
        raddr_b = y_hi ? idx - StrideY : idx + StrideY;
      end
      default: begin
        raddr_a = z_lo ? idx + StrideZ : idx - StrideZ;
        raddr_b = z_hi ? idx - StrideZ : idx + StrideZ;
      end
    endcase
  end

  logic [DATA_W-1:0] temp_a, temp_b, heat_a;

  hs3d_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_temp_ram (
    .clk_i     (clk_i),
    .we_i      (cmd_i.load_wr),
    .waddr_i   (in_idx),
    .wdata_i   (in_data_i.temp_in),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (temp_a),
    .rdata_b_o (temp_b)
  );

  hs3d_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_heat_ram (
    .clk_i     (clk_i),
    .we_i      (cmd_i.load_wr),
    .waddr_i   (in_idx),
    .wdata_i   (in_data_i.heat_in),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_a),
    .rdata_a_o (heat_a),
    .rdata_b_o ()
  );

  logic signed [DATA_W-1:0] t0_q, heat_q;
  logic signed [DIFF_W-1:0] diff_q, diff_d;
  logic signed [ACC_W-1:0]  prod_q, acc_q;

  logic signed [DIFF_W-1:0] ta_ext, tb_ext, t0_ext;
  logic                     interior;
  assign ta_ext = DIFF_W'(signed'(temp_a));
  assign tb_ext = DIFF_W'(signed'(temp_b));
  assign t0_ext = DIFF_W'(t0_q);

  always_comb begin
    unique case (cmd_i.diff_axis)
      AXIS_X:  interior = !x_lo && !x_hi;
      AXIS_Y:  interior = !y_lo && !y_hi;
      default: interior = !z_lo && !z_hi;
    endcase
    diff_d = interior ? (ta_ext + tb_ext - (t0_ext <<< 1)) : (ta_ext - t0_ext);
  end

  // shared multiplier, operands chosen per step
  logic signed [DATA_W:0]          mul_a;
  logic signed [DIFF_W-1:0]        mul_b;
  logic signed [DATA_W+DIFF_W:0]   mul_p, mul_sh;
  logic [COEF_W-1:0]               conv_gain;

  always_comb begin
    if (cool_face_q == FACE_X && x_lo) begin
      conv_gain = gain_x_q;
    end else if (cool_face_q == FACE_Z && z_lo) begin
      conv_gain = gain_z_q;
    end else begin
      conv_gain = '0;
    end
    unique case (cmd_i.mul_sel)
      MUL_SRC: begin
        mul_a = signed'({1'b0, src_gain_q});
        mul_b = DIFF_W'(heat_q);
      end
      MUL_X: begin
        mul_a = signed'((DATA_W + 1)'(coef_x_q));
        mul_b = diff_q;
      end
      MUL_Y: begin
        mul_a = signed'((DATA_W + 1)'(coef_y_q));
        mul_b = diff_q;
      end
      MUL_Z: begin
        mul_a = signed'((DATA_W + 1)'(coef_z_q));
        mul_b = diff_q;
      end
      default: begin
        mul_a = signed'((DATA_W + 1)'(conv_gain));
        mul_b = DIFF_W'(coolant_q) - t0_ext;
      end
    endcase
    mul_p  = mul_a * mul_b;
    mul_sh = (cmd_i.mul_sel == MUL_SRC) ? (mul_p >>> 32) : (mul_p >>> 16);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_center) begin
      t0_q   <= signed'(temp_a);
      heat_q <= signed'(heat_a);
    end
    if (cmd_i.ld_diff) begin
      diff_q <= diff_d;
    end
    prod_q <= ACC_W'(mul_sh);
    if (cmd_i.ld_center) begin
      acc_q <= ACC_W'(signed'(temp_a));
    end else if (cmd_i.acc_en) begin
      acc_q <= acc_q + prod_q;
    end
  end

  logic signed [DATA_W-1:0] sat;
  always_comb begin
    if (acc_q[ACC_W-1:DATA_W-1] == '0 || acc_q[ACC_W-1:DATA_W-1] == '1) begin
      sat = acc_q[DATA_W-1:0];
    end else if (!acc_q[ACC_W-1]) begin
      sat = {1'b0, {(DATA_W - 1){1'b1}}};
    end else begin
      sat = {1'b1, {(DATA_W - 1){1'b0}}};
    end
  end

  out_item_t out_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.temp_next <= cmd_i.out_result ? sat : '0;
      out_q.is_update <= cmd_i.out_update;
    end
  end
  assign out_data_o = out_q;

endmodule

@@ hw/rtl/hs3d_ctrl.sv @@
// controller: accepts items, sequences the stencil reads and multiplies,
// owns the result valid flag; depends on hs3d_pkg
module hs3d_ctrl import hs3d_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e              state_q, state_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic                out_vld_q, out_vld_d;
  logic                slot_free, accept;

  assign slot_free  = !out_vld_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && slot_free;
  assign accept     = in_valid_i && in_ready_o;
  assign out_valid_o = out_vld_q;

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    out_vld_d = out_vld_q && !out_ready_i;
    cmd_o     = '0;
    cmd_o.rd_sel    = RD_CENTER;
    cmd_o.diff_axis = AXIS_X;
    cmd_o.mul_sel   = MUL_SRC;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.capture = 1'b1;
          if (status_i.item_compute && status_i.item_inside) begin
            state_d = ST_RUN;
            step_d  = '0;
          end else begin
            // loads and out-of-grid computes answer at once with zero
            cmd_o.load_wr    = !status_i.item_compute && status_i.item_inside;
            cmd_o.out_load   = 1'b1;
            cmd_o.out_update = status_i.item_compute;
            out_vld_d        = 1'b1;
          end
        end
      end
      ST_RUN: begin
        step_d = step_q + 1'b1;
        unique case (step_q)
          3'd0: cmd_o.rd_sel = RD_CENTER;
          3'd1: begin
            cmd_o.rd_sel    = RD_X;
            cmd_o.ld_center = 1'b1;
          end
          3'd2: begin
            cmd_o.rd_sel    = RD_Y;
            cmd_o.ld_diff   = 1'b1;
            cmd_o.diff_axis = AXIS_X;
            cmd_o.mul_sel   = MUL_SRC;
          end
          3'd3: begin
            cmd_o.rd_sel    = RD_Z;
            cmd_o.ld_diff   = 1'b1;
            cmd_o.diff_axis = AXIS_Y;
            cmd_o.mul_sel   = MUL_X;
            cmd_o.acc_en    = 1'b1;
          end
          3'd4: begin
            cmd_o.ld_diff   = 1'b1;
            cmd_o.diff_axis = AXIS_Z;
            cmd_o.mul_sel   = MUL_Y;
            cmd_o.acc_en    = 1'b1;
          end
          3'd5: begin
            cmd_o.mul_sel = MUL_Z;
            cmd_o.acc_en  = 1'b1;
          end
          3'd6: begin
            cmd_o.mul_sel = MUL_CONV;
            cmd_o.acc_en  = 1'b1;
          end
          default: begin
            cmd_o.acc_en = 1'b1;
            state_d      = ST_DONE;
          end
        endcase
      end
      default: begin
        if (slot_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_result = 1'b1;
          cmd_o.out_update = 1'b1;
          out_vld_d        = 1'b1;
          state_d          = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      step_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      out_vld_q <= out_vld_d;
    end
  end

endmodule

@@ hw/rtl/heat_stencil_3d_convective_step_core.sv @@
// load item: result in the cycle after acceptance; one load accepted per cycle while
// results are taken. compute item: no new item is taken until its result is registered;
// seven temperatures come through the two read ports of the temperature store in
// four reads, and five products go one per cycle through a single multiplier.
// reset clears control state and config registers; voxel stores keep their contents.
module heat_stencil_3d_convective_step_core import hs3d_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  hs3d_in_if.sink              in_i,
  hs3d_out_if.source           out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  hs3d_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  hs3d_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_i.data),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_o.data)
  );

endmodule

@@ hw/rtl/hs3d_checker.sv @@
// port-level checker for the heat stencil core, bound to the top level
// depends on hs3d_pkg and the macro header
`include "heat_stencil_3d_convective_step_core_macros.svh"

module hs3d_checker import hs3d_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     in_action,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [DATA_W-1:0] out_temp_next,
  input logic                     out_is_update
);

  `HS3D_ASSERT(a_load_result_zero, out_valid && !out_is_update |-> out_temp_next == '0, "load item result not zero")
  `HS3D_ASSERT_NEXT(a_compute_blocks_input, in_valid && in_ready && in_action, !in_ready, "input taken during compute")
  `HS3D_ASSERT_NEXT(a_out_valid_holds, out_valid && !out_ready, out_valid, "result dropped")
  `HS3D_ASSERT_NEXT(a_out_data_holds, out_valid && !out_ready, $stable(out_temp_next) && $stable(out_is_update), "stalled result changed")

endmodule

bind heat_stencil_3d_convective_step_core hs3d_checker u_hs3d_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid      (in_i.valid),
  .in_ready      (in_i.ready),
  .in_action     (in_i.data.action),
  .out_valid     (out_o.valid),
  .out_ready     (out_o.ready),
  .out_temp_next (out_o.data.temp_next),
  .out_is_update (out_o.data.is_update)
);

@@ tb/hs3d_step_checker.sv @@
// checker for the 3d heat stencil core: watches both item channels and the config port,
// predicts the next temperature of each voxel and compares every result item
// depends on hs3d_pkg, hs3d_in_if and hs3d_out_if
module hs3d_step_checker import hs3d_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  hs3d_in_if                   in_ch,
  hs3d_out_if                  out_ch,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  logic [COEF_W-1:0] k_x, k_y, k_z, h_x, h_z;
  logic [1:0]        face_raw;
  logic signed [31:0] t_cool;
  logic [31:0]       q_gain;

  logic signed [31:0] temp_mem [CELLS];
  logic signed [31:0] heat_mem [CELLS];

  out_item_t next_temp_q[$];
  int        fails;

  assign fail_count_o = fails;
  assign pending_o    = next_temp_q.size();

  function automatic longint diffusion(logic [COEF_W-1:0] k, int p, int n, int idx, int stride);
    longint t0, d;
    t0 = temp_mem[idx];
    if (p > 0 && p < n - 1) begin
      d = longint'(temp_mem[idx-stride]) - 2 * t0 + longint'(temp_mem[idx+stride]);
    end else if (p == 0) begin
      d = longint'(temp_mem[idx+stride]) - t0;
    end else begin
      d = longint'(temp_mem[idx-stride]) - t0;
    end
    return (longint'({48'd0, k}) * d) >>> 16;
  endfunction

  function automatic out_item_t next_temperature(in_item_t it);
    out_item_t r;
    int x, y, z, idx;
    longint t0, acc;
    r.temp_next = '0;
    r.is_update = it.action;
    x = it.pos_x;
    y = it.pos_y;
    z = it.pos_z;
    idx = (z * GRID_Y + y) * GRID_X + x;
    if (it.action == ACT_LOAD) begin
      temp_mem[idx] = it.temp_in;
      heat_mem[idx] = it.heat_in;
      return r;
    end
    t0  = temp_mem[idx];
    acc = t0;
    acc += diffusion(k_x, x, GRID_X, idx, 1);
    acc += diffusion(k_y, y, GRID_Y, idx, GRID_X);
    acc += diffusion(k_z, z, GRID_Z, idx, GRID_X * GRID_Y);
    if (x == 0 && face_raw == FACE_X)
      acc += (longint'({48'd0, h_x}) * (longint'(t_cool) - t0)) >>> 16;
    if (z == 0 && face_raw == FACE_Z)
      acc += (longint'({48'd0, h_z}) * (longint'(t_cool) - t0)) >>> 16;
    acc += (longint'({32'd0, q_gain}) * longint'(heat_mem[idx])) >>> 32;
    if (acc > longint'(32'sh7fffffff)) acc = 32'sh7fffffff;
    if (acc < -longint'(64'h80000000)) acc = -longint'(64'h80000000);
    r.temp_next = acc[31:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_x = '0; k_y = '0; k_z = '0; h_x = '0; h_z = '0;
      face_raw = '0; t_cool = '0; q_gain = '0;
      fails = 0;
      next_temp_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_COEF_X:       k_x = cfg_data_i[COEF_W-1:0];
          REG_COEF_Y:       k_y = cfg_data_i[COEF_W-1:0];
          REG_COEF_Z:       k_z = cfg_data_i[COEF_W-1:0];
          REG_CONV_GAIN_X:  h_x = cfg_data_i[COEF_W-1:0];
          REG_CONV_GAIN_Z:  h_z = cfg_data_i[COEF_W-1:0];
          REG_COOL_FACE:    face_raw = cfg_data_i[1:0];
          REG_COOLANT_TEMP: t_cool = cfg_data_i;
          REG_SOURCE_GAIN:  q_gain = cfg_data_i;
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (next_temp_q.size() == 0) begin
          $error("result item with none expected: temp_next %0d is_update %0b",
                 out_ch.data.temp_next, out_ch.data.is_update);
          fails++;
        end else begin
          out_item_t e;
          e = next_temp_q.pop_front();
          if (out_ch.data.temp_next !== e.temp_next) begin
            $error("temp_next: expected %0d, actual %0d", e.temp_next, out_ch.data.temp_next);
            fails++;
          end
          if (out_ch.data.is_update !== e.is_update) begin
            $error("is_update: expected %0b, actual %0b", e.is_update, out_ch.data.is_update);
            fails++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        next_temp_q.push_back(next_temperature(in_ch.data));
    end
  end

endmodule

@@ tb/heat_stencil_3d_convective_step_core_tb.sv @@
// testbench top for the 3d heat stencil core: clock, reset, stimulus and verdict
// depends on hs3d_pkg, both channel interfaces, the core and hs3d_step_checker
module heat_stencil_3d_convective_step_core_tb;
  import hs3d_pkg::*;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [DATA_W-1:0]    cfg_data;
  int                   fail_count, pending;
  bit                   tx_burst, rx_burst, rx_hold_req;

  hs3d_in_if  in_ch ();
  hs3d_out_if out_ch ();

  heat_stencil_3d_convective_step_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  hs3d_step_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  // result side: random stalls, stretches without stalls, one long hold
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    wait (rst_ni);
    forever begin
      gap = rx_burst ? 0 : $urandom_range(0, 17);
      if (rx_hold_req) begin
        gap = 300;
        rx_hold_req = 1'b0;
      end
      @(negedge clk_i);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
      if ($urandom_range(0, 40) == 0) rx_burst = !rx_burst;
    end
  end

  task automatic send(in_item_t it);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 17);
    @(negedge clk_i);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    if ($urandom_range(0, 40) == 0) tx_burst = !tx_burst;
  endtask

  task automatic load(int x, int y, int z, logic [31:0] t, logic [31:0] h);
    in_item_t it;
    it.action  = ACT_LOAD;
    it.pos_x   = POS_X_W'(x);
    it.pos_y   = POS_Y_W'(y);
    it.pos_z   = POS_Z_W'(z);
    it.temp_in = t;
    it.heat_in = h;
    send(it);
  endtask

  task automatic compute(int x, int y, int z);
    in_item_t it;
    it.action  = ACT_COMPUTE;
    it.pos_x   = POS_X_W'(x);
    it.pos_y   = POS_Y_W'(y);
    it.pos_z   = POS_Z_W'(z);
    it.temp_in = $urandom;
    it.heat_in = $urandom;
    send(it);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    wait (pending == 0);
    // a compute may still be in flight after the last result
    repeat (15) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_reg_e r, logic [31:0] v);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= r;
    cfg_data <= v;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  task automatic set_config(logic [15:0] kx, ky, kz, gx, gz, logic [1:0] face,
                            logic [31:0] cool, sg);
    drain();
    cfg_write(REG_COEF_X, 32'(kx));
    cfg_write(REG_COEF_Y, 32'(ky));
    cfg_write(REG_COEF_Z, 32'(kz));
    cfg_write(REG_CONV_GAIN_X, 32'(gx));
    cfg_write(REG_CONV_GAIN_Z, 32'(gz));
    cfg_write(REG_COOL_FACE, 32'(face));
    cfg_write(REG_COOLANT_TEMP, cool);
    cfg_write(REG_SOURCE_GAIN, sg);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return 32'hffffffff;
      4: return $urandom_range(0, 32'h000fffff) - 32'h00080000;
      default: return $urandom;
    endcase
  endfunction

  // computes stay on the two outer layers of each axis
  function automatic int rand_pos(int n);
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 1;
      2: return n - 2;
      default: return n - 1;
    endcase
  endfunction

  // voxels a compute can read: three outer layers of each axis
  function automatic bit near_edge(int p, int n);
    return (p < 3) || (p > n - 4);
  endfunction

  initial begin
    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_data     = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    tx_burst     = 1'b0;
    rx_burst     = 1'b0;
    rx_hold_req  = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // every voxel a compute can read holds data before it is read
    tx_burst = 1'b1;
    for (int z = 0; z < GRID_Z; z++)
      for (int y = 0; y < GRID_Y; y++)
        for (int x = 0; x < GRID_X; x++)
          if (near_edge(x, GRID_X) && near_edge(y, GRID_Y) && near_edge(z, GRID_Z))
            load(x, y, z, rand_word(), rand_word());
    tx_burst = 1'b0;

    // saturation at both ends with the largest coefficients
    set_config(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, FACE_X,
               32'h80000000, 32'hffffffff);
    load(1, 1, 1, 32'h7fffffff, 32'h7fffffff);
    load(0, 1, 1, 32'h80000000, 32'h80000000);
    load(2, 1, 1, 32'h80000000, 32'h0);
    load(1, 0, 1, 32'h80000000, 32'h0);
    load(1, 2, 1, 32'h80000000, 32'h0);
    load(1, 1, 0, 32'h80000000, 32'h80000000);
    load(1, 1, 2, 32'h80000000, 32'h0);
    compute(1, 1, 1);
    compute(0, 1, 1);
    compute(1, 1, 0);
    compute(0, 0, 0);
    compute(15, 15, 7);
    set_config(16'hffff, 16'h0, 16'hffff, 16'h0, 16'hffff, FACE_Z,
               32'h7fffffff, 32'h0);
    compute(1, 1, 0);
    compute(0, 0, 0);
    compute(15, 0, 0);
    // unused face code: no cooling anywhere
    set_config(16'h8000, 16'h8000, 16'h8000, 16'hffff, 16'hffff, 2'd3,
               32'h7fffffff, 32'h80000000);
    compute(0, 0, 0);
    compute(1, 1, 1);

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_config('0, '0, '0, '0, '0, FACE_NONE, '0, '0);
        1: set_config('1, '1, '1, '1, '1, FACE_X, '1, '1);
        default: set_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom), 2'($urandom_range(0, 3)), rand_word(),
                            $urandom);
      endcase
      if (phase == 2) rx_hold_req = 1'b1;
      for (int n = 0; n < 70; n++) begin
        if ($urandom_range(0, 99) < 35)
          load(rand_pos(GRID_X), rand_pos(GRID_Y), rand_pos(GRID_Z), rand_word(), rand_word());
        else
          compute(rand_pos(GRID_X), rand_pos(GRID_Y), rand_pos(GRID_Z));
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
